// File: sv/gtb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtb_pkg
// Shared constants and color helpers for the gradient table builder.
// ----------------------------------------------------------------------------
package gtb_pkg;

    localparam int DEFAULT_TABLE_DEPTH   = 256;
    localparam int DEFAULT_FRACTION_BITS = 23;

    localparam int CFG_W      = 11;
    localparam int OFFSET_W   = 17;
    localparam int COLOR_IN_W = 64;
    localparam int INDEX_W    = 10;
    localparam int PIXEL_W    = 32;
    localparam int POS_W      = 18;

    localparam logic [CFG_W-1:0]    ENTRIES_RESET = 11'd256;
    localparam logic [OFFSET_W-1:0] OFFSET_ONE    = 17'd65536;

    // Command codes carried on the input tuser.
    localparam logic CMD_ADD_STOP = 1'b0;
    localparam logic CMD_READ     = 1'b1;

    // Keeps the high byte of each 16-bit channel.
    function automatic logic [PIXEL_W-1:0] narrow_color(input logic [COLOR_IN_W-1:0] c);
        return {c[63:56], c[47:40], c[31:24], c[15:8]};
    endfunction

    // Rounded division by 255 of an 8x8 product.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        logic [16:0] s;
        t = {1'b0, x} + 17'd128;
        s = t + {8'd0, t[16:8]};
        return s[15:8];
    endfunction

    // Premultiplies red, green and blue by alpha; alpha is kept.
    function automatic logic [PIXEL_W-1:0] premultiply(input logic [PIXEL_W-1:0] c);
        logic [7:0] a;
        a = c[31:24];
        return {a, div255(16'(c[23:16]) * 16'(a)), div255(16'(c[15:8]) * 16'(a)),
                div255(16'(c[7:0]) * 16'(a))};
    endfunction

endpackage

// File: sv/gtb_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtb_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gtb_divider #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] dvd_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, dvd_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            den_reg <= divisor;
            quo_reg <= '0;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << 1;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: sv/gradient_table_builder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_table_builder_unit
// Builds a premultiplied ARGB32 gradient table from color stops.
// ----------------------------------------------------------------------------
// Usage:
// Stop and read commands arrive as beats on the s_ channel; every accepted beat
// returns exactly one result beat on the m_ channel. A stop beat answers with a
// zero pixel and the table-ready flag; a read beat answers with the stored entry
// (zero for an index at or beyond the table depth).
// The table lives in one synchronous RAM with one read port and one write
// port. A read passes through the read state and the result state. A stop
// passes through the calc and segment states, then four divisions, one per
// channel, in the bit-serial divider when its span length is more than one,
// then one RAM write per entry of the span, and on the last stop one write per
// remaining entry up to entries_in_use. The RAM write port, one entry per
// cycle, sets the fill time of a full table, along with the division.
// One command is worked at a time; s_tready is high only while idle.
// A finished result waits in the output register while the next beat is
// worked; if the receiver stalls, the block holds that next result in its
// result state and accepts nothing more until the output register drains.
// Reset clears the sequencer, gradient and output-valid state and sets
// entries_in_use to 256; the table contents are undefined until written.
// The configuration channel is always ready and should be written while idle.
// ----------------------------------------------------------------------------
module gradient_table_builder_unit #(
    parameter int TABLE_DEPTH   = gtb_pkg::DEFAULT_TABLE_DEPTH,
    parameter int FRACTION_BITS = gtb_pkg::DEFAULT_FRACTION_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Command channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [16:0] stop_offset, [80:17] stop_color, [90:81] read_index, [95:91] zero
    input  logic [95:0] s_tdata,
    input  logic        s_tlast,   // last_stop
    input  logic        s_tuser,   // command
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] read_pixel, [32] table_ready, [39:33] zero
    output logic [39:0] m_tdata,
    // Configuration: entries_in_use.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);

    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NUM_W  = 8 + FRACTION_BITS;
    localparam int STEP_W = FRACTION_BITS + 9;
    localparam int ACC_W  = FRACTION_BITS + 10;
    localparam int CW     = gtb_pkg::CFG_W;
    localparam int IW     = gtb_pkg::INDEX_W;
    localparam int PW     = gtb_pkg::PIXEL_W;
    localparam int QW     = gtb_pkg::POS_W;
    localparam logic [CW-1:0] DEPTH_L = CW'(TABLE_DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_CALC = 3'd2;
    localparam logic [2:0] ST_SEG  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_SPAN = 3'd5;
    localparam logic [2:0] ST_FILL = 3'd6;
    localparam logic [2:0] ST_RESP = 3'd7;

    logic [2:0]  state_reg;
    logic [CW-1:0] entries_reg;

    // Stop being worked on.
    logic [gtb_pkg::OFFSET_W-1:0] off_reg;
    logic [PW-1:0] col_reg;
    logic          last_reg;
    logic [CW-1:0] e_reg;
    logic [QW-1:0] pos_reg;
    logic          skip_reg;

    // Gradient state.
    logic [QW-1:0] prev_pos_reg;
    logic [PW-1:0] prev_color_reg;
    logic [PW-1:0] first_color_reg;
    logic [CW-1:0] wp_reg;
    logic [CW-1:0] stop_count_reg;
    logic          ready_reg;

    // Span engine.
    logic [IW-1:0] from_reg;
    logic [IW-1:0] n_reg;
    logic [IW-1:0] k_reg;
    logic [1:0]    ch_reg;
    logic [CW-1:0] fill_idx_reg;
    logic signed [ACC_W-1:0]  acc_reg  [4];
    logic signed [STEP_W-1:0] step_reg [4];
    logic          div_start_reg;

    // Result.
    logic [PW-1:0] res_pixel_reg;
    logic          rd_in_range_reg;
    logic          m_valid_reg;
    logic [PW-1:0] m_pixel_reg;
    logic          m_ready_flag_reg;

    // Table RAM.
    logic [PW-1:0] mem [TABLE_DEPTH];
    logic [PW-1:0] mem_rd_data_reg;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_wr_addr;
    logic [PW-1:0] mem_wr_data;

    // Combinational helpers.
    logic          s_fire;
    logic [CW-1:0] e_clamped;
    logic [27:0]   pos_prod;
    logic          fresh;
    logic [QW-1:0] pos_clamped;
    logic [IW-1:0] seg_from;
    logic [IW-1:0] seg_n;
    logic signed [8:0] d_ch [4];
    logic [7:0]    abs_d;
    logic          div_done;
    logic [NUM_W-1:0] div_quo;
    logic signed [STEP_W-1:0] div_step;
    logic [CW-1:0] span_addr;
    logic [PW-1:0] span_pix;
    logic [PW-1:0] fill_pix;
    logic          out_free;

    assign s_fire    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    assign e_clamped = (entries_reg < CW'(2)) ? CW'(2) :
                       (entries_reg > DEPTH_L) ? DEPTH_L : entries_reg;
    assign pos_prod  = off_reg * (e_reg - 1'b1) + 28'd128;
    assign fresh     = ready_reg || (stop_count_reg == '0);

    assign pos_clamped = (pos_reg < prev_pos_reg) ? prev_pos_reg : pos_reg;
    assign seg_from    = prev_pos_reg[QW-1:8];
    assign seg_n       = pos_clamped[QW-1:8] - seg_from;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            d_ch[c] = $signed({1'b0, col_reg[8*c +: 8]}) - $signed({1'b0, prev_color_reg[8*c +: 8]});
        end
    end

    assign abs_d    = d_ch[ch_reg][8] ? 8'(-d_ch[ch_reg]) : d_ch[ch_reg][7:0];
    assign div_step = d_ch[ch_reg][8] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

    gtb_divider #(
        .NUM_W (NUM_W),
        .DEN_W (IW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend ({abs_d, {FRACTION_BITS{1'b0}}}),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Pixel of the current span entry: integer part of each accumulator.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            span_pix[8*c +: 8] = acc_reg[c][FRACTION_BITS +: 8];
        end
    end

    assign span_addr = {1'b0, from_reg} + {1'b0, k_reg};
    assign fill_pix  = gtb_pkg::premultiply(col_reg);

    // RAM port control.
    always_comb begin
        mem_we      = 1'b0;
        mem_wr_addr = span_addr[AW-1:0];
        mem_wr_data = gtb_pkg::premultiply(span_pix);
        case (state_reg)
            ST_SPAN: begin
                mem_we = span_addr < DEPTH_L;
            end
            ST_FILL: begin
                if (fill_idx_reg < e_reg) begin
                    mem_we      = 1'b1;
                    mem_wr_addr = fill_idx_reg[AW-1:0];
                    mem_wr_data = fill_pix;
                end else begin
                    // Entry 0 always takes the first stop's color.
                    mem_we      = 1'b1;
                    mem_wr_addr = '0;
                    mem_wr_data = gtb_pkg::premultiply(first_color_reg);
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign mem_rd_en   = s_fire && (s_tuser == gtb_pkg::CMD_READ);
    assign mem_rd_addr = s_tdata[81 +: AW];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            mem_rd_data_reg <= mem[mem_rd_addr];
        end
    end

    // Control sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            entries_reg      <= gtb_pkg::ENTRIES_RESET;
            prev_pos_reg     <= '0;
            prev_color_reg   <= '0;
            first_color_reg  <= '0;
            wp_reg           <= '0;
            stop_count_reg   <= '0;
            ready_reg        <= 1'b0;
            div_start_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                entries_reg <= cfg_data;
            end
            // In the result state the output register is reloaded below instead.
            if (m_valid_reg && m_tready && (state_reg != ST_RESP)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        res_pixel_reg   <= '0;
                        off_reg         <= (s_tdata[16:0] > gtb_pkg::OFFSET_ONE) ?
                                           gtb_pkg::OFFSET_ONE : s_tdata[16:0];
                        col_reg         <= gtb_pkg::narrow_color(s_tdata[80:17]);
                        last_reg        <= s_tlast;
                        e_reg           <= e_clamped;
                        rd_in_range_reg <= {1'b0, s_tdata[90:81]} < DEPTH_L;
                        state_reg       <= (s_tuser == gtb_pkg::CMD_READ) ? ST_RD : ST_CALC;
                    end
                end
                ST_RD: begin
                    res_pixel_reg <= rd_in_range_reg ? mem_rd_data_reg : '0;
                    state_reg     <= ST_RESP;
                end
                ST_CALC: begin
                    pos_reg   <= pos_prod[QW+7:8];
                    ready_reg <= 1'b0;
                    if (fresh) begin
                        first_color_reg <= col_reg;
                        prev_color_reg  <= col_reg;
                        prev_pos_reg    <= '0;
                        wp_reg          <= '0;
                        stop_count_reg  <= CW'(1);
                        skip_reg        <= (off_reg == '0) && !last_reg;
                    end else begin
                        skip_reg <= 1'b0;
                        if (stop_count_reg != '1) begin
                            stop_count_reg <= stop_count_reg + 1'b1;
                        end
                    end
                    state_reg <= ST_SEG;
                end
                ST_SEG: begin
                    if (skip_reg) begin
                        // A leading stop at offset zero that is not the last only sets the start color.
                        state_reg <= ST_RESP;
                    end else begin
                        pos_reg  <= pos_clamped;
                        from_reg <= seg_from;
                        n_reg    <= seg_n;
                        k_reg    <= '0;
                        ch_reg   <= '0;
                        for (int c = 0; c < 4; c++) begin
                            acc_reg[c]  <= $signed({2'b00, prev_color_reg[8*c +: 8], 1'b1,
                                                    {(FRACTION_BITS-1){1'b0}}});
                            step_reg[c] <= $signed({d_ch[c], {FRACTION_BITS{1'b0}}});
                        end
                        if (seg_n > IW'(1)) begin
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_DIV;
                        end else begin
                            state_reg <= ST_SPAN;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        step_reg[ch_reg] <= div_step;
                        if (ch_reg == 2'd3) begin
                            state_reg <= ST_SPAN;
                        end else begin
                            ch_reg        <= ch_reg + 1'b1;
                            div_start_reg <= 1'b1;
                        end
                    end
                end
                ST_SPAN: begin
                    for (int c = 0; c < 4; c++) begin
                        acc_reg[c] <= acc_reg[c] + ACC_W'(step_reg[c]);
                    end
                    if (k_reg == n_reg) begin
                        wp_reg         <= span_addr + 1'b1;
                        fill_idx_reg   <= span_addr + 1'b1;
                        prev_pos_reg   <= pos_reg;
                        prev_color_reg <= col_reg;
                        state_reg      <= last_reg ? ST_FILL : ST_RESP;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_FILL: begin
                    if (fill_idx_reg < e_reg) begin
                        fill_idx_reg <= fill_idx_reg + 1'b1;
                    end else begin
                        if (wp_reg < e_reg) begin
                            wp_reg <= e_reg;
                        end
                        ready_reg <= 1'b1;
                        state_reg <= ST_RESP;
                    end
                end
                ST_RESP: begin
                    if (out_free) begin
                        m_valid_reg      <= 1'b1;
                        m_pixel_reg      <= res_pixel_reg;
                        m_ready_flag_reg <= ready_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_ready_flag_reg, m_pixel_reg};

    // The table is only written while a stop is being worked.
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_RESP || state_reg == ST_RD) |-> !mem_we)
        else $error("table written outside a stop");

    // The span counter never runs past the span length.
    a_span_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SPAN) |-> (k_reg <= n_reg))
        else $error("span counter overran");

    // Finishing the fill marks the table ready.
    a_fill_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL && fill_idx_reg >= e_reg) |=> ready_reg)
        else $error("table not marked ready after fill");

    // A result is loaded only when the output register can take it.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_pixel_reg)))
        else $error("pending result overwritten");

endmodule

// File: verif/gradient_table_builder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_table_builder_unit_tb
// Self-checking bench for the gradient table builder.
// ----------------------------------------------------------------------------
// Stop and read beats are sent with random gaps while the result side stalls
// at random. A behavioral table model inside the bench works out the pixel and
// the ready flag for every beat; results are checked in order against it.
// Reads target entries that the current or an earlier gradient wrote, or beyond the table.
// ----------------------------------------------------------------------------
module gradient_table_builder_unit_tb;

    localparam int DEPTH = gtb_pkg::DEFAULT_TABLE_DEPTH;
    localparam int FRAC  = gtb_pkg::DEFAULT_FRACTION_BITS;
    localparam int STALL_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [16:0] stop_offset, [80:17] stop_color, [90:81] read_index, [95:91] zero
    logic [95:0] s_tdata;
    logic        s_tlast;   // last_stop
    logic        s_tuser;   // command
    logic        m_tvalid;
    logic        m_tready;
    // [31:0] read_pixel, [32] table_ready, [39:33] zero
    logic [39:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;

    typedef struct packed {
        logic [31:0] pixel;
        logic        ready;
    } result_t;

    result_t     pending_results[$];
    int          error_count;
    int          idle_cycles;
    bit          hold_off;      // long receiver stall requested
    bit          rx_random;

    // Model state.
    logic [31:0] lut[DEPTH];
    bit          lut_valid[DEPTH];
    logic [17:0] prev_pos;
    logic [31:0] prev_col;
    logic [31:0] first_col;
    int unsigned wr_ptr;
    int unsigned stops_seen;
    bit          table_done;
    logic [10:0] entries_reg;

    gradient_table_builder_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Rounded x * a / 255, written independently of the package helper.
    function automatic logic [7:0] scale_by_alpha(input int unsigned x, input int unsigned a);
        int unsigned t;
        t = x * a + 128;
        return 8'((t + (t >> 8)) >> 8);
    endfunction

    function automatic logic [31:0] premul_pixel(input logic [31:0] c);
        return {c[31:24], scale_by_alpha(c[23:16], c[31:24]),
                scale_by_alpha(c[15:8], c[31:24]), scale_by_alpha(c[7:0], c[31:24])};
    endfunction

    task automatic store_entry(input int unsigned idx, input logic [31:0] v);
        if (idx < DEPTH) begin
            lut[idx] = v;
            lut_valid[idx] = 1'b1;
        end
    endtask

    // Interpolates from the previous stop up to position pos.
    task automatic fill_span(input logic [17:0] pos_in, input logic [31:0] c1);
        logic [17:0] pos;
        int unsigned from_idx, n;
        longint acc[4];
        longint stp[4];
        longint s, d;
        logic [31:0] pix;
        pos = pos_in < prev_pos ? prev_pos : pos_in;
        from_idx = prev_pos >> 8;
        n = (pos >> 8) - from_idx;
        if (n <= 1) begin
            store_entry(from_idx, premul_pixel(prev_col));
            wr_ptr = from_idx + 1;
            if (n == 1) begin
                store_entry(from_idx + 1, premul_pixel(c1));
                wr_ptr = from_idx + 2;
            end
        end else begin
            for (int ch = 0; ch < 4; ch++) begin
                s = (prev_col >> (8 * ch)) & 8'hFF;
                d = longint'((c1 >> (8 * ch)) & 8'hFF) - s;
                stp[ch] = (d * (64'sd1 <<< FRAC)) / longint'(n);
                acc[ch] = s * (64'sd1 <<< FRAC) + (64'sd1 <<< (FRAC - 1));
            end
            for (int unsigned k = 0; k <= n; k++) begin
                for (int ch = 0; ch < 4; ch++) begin
                    pix[8*ch +: 8] = 8'(acc[ch] >>> FRAC);
                    acc[ch] += stp[ch];
                end
                store_entry(from_idx + k, premul_pixel(pix));
            end
            wr_ptr = from_idx + n + 1;
        end
        prev_pos = pos;
        prev_col = c1;
    endtask

    task automatic model_stop(input logic [16:0] off_in, input logic [63:0] col_in,
                              input bit last);
        int unsigned e, off;
        logic [17:0] pos;
        logic [31:0] col;
        logic [31:0] fill;
        e = entries_reg < 2 ? 2 : (entries_reg > DEPTH ? DEPTH : entries_reg);
        off = off_in > 65536 ? 65536 : off_in;
        pos = 18'((off * (e - 1) + 128) >> 8);
        col = {col_in[63:56], col_in[47:40], col_in[31:24], col_in[15:8]};
        if (table_done) begin
            table_done = 1'b0;
            stops_seen = 0;
        end
        if (stops_seen == 0) begin
            first_col = col;
            prev_col = col;
            prev_pos = '0;
            wr_ptr = 0;
            if (!(off == 0 && !last)) fill_span(pos, col);
        end else begin
            fill_span(pos, col);
        end
        if (stops_seen < 2047) stops_seen++;
        if (last) begin
            fill = premul_pixel(prev_col);
            for (int unsigned i = wr_ptr; i < e; i++) store_entry(i, fill);
            if (wr_ptr < e) wr_ptr = e;
            store_entry(0, premul_pixel(first_col));
            table_done = 1'b1;
        end
    endtask

    // Sends one beat after a random gap and queues its expected result.
    // s_tvalid stays high after the accepting edge; the block is busy then, and
    // the next call drops it or sends the next beat, or wait_drained takes it down.
    task automatic send_beat(input bit cmd, input logic [16:0] off, input logic [63:0] col,
                             input bit last, input logic [9:0] idx);
        result_t r;
        int unsigned gap;
        gap = $urandom_range(0, 8);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tlast  <= last;
        s_tdata  <= {5'd0, idx, col, off};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == gtb_pkg::CMD_ADD_STOP) model_stop(off, col, last);
        r.pixel = (cmd == gtb_pkg::CMD_READ && idx < DEPTH) ? lut[idx] : 32'd0;
        r.ready = table_done;
        pending_results.push_back(r);
    endtask

    task automatic read_entry(input logic [9:0] idx);
        send_beat(gtb_pkg::CMD_READ, 17'($urandom), {$urandom, $urandom},
                  1'($urandom_range(0, 1)), idx);
    endtask

    task automatic add_stop(input logic [16:0] off, input logic [63:0] col, input bit last);
        send_beat(gtb_pkg::CMD_ADD_STOP, off, col, last, 10'($urandom));
    endtask

    // Random read that only targets written entries, or beyond the table.
    task automatic read_random;
        int unsigned idx;
        if ($urandom_range(0, 9) == 0) idx = $urandom_range(DEPTH, 1023);
        else begin
            idx = $urandom_range(0, DEPTH - 1);
            for (int t = 0; t < DEPTH && !lut_valid[idx]; t++) idx = (idx + 1) % DEPTH;
            if (!lut_valid[idx]) idx = DEPTH;
        end
        read_entry(10'(idx));
    endtask

    task automatic wait_drained;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_entries(input logic [10:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        entries_reg = v;
    endtask

    function automatic logic [63:0] random_color;
        return {$urandom, $urandom};
    endfunction

    // Random gradient: 1..6 stops, mostly at nondecreasing offsets.
    task automatic build_gradient;
        int unsigned n, off;
        n = $urandom_range(1, 6);
        off = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 20000);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) off = $urandom_range(0, 131071);
            add_stop(17'(off), random_color(), i == n - 1);
            if ($urandom_range(0, 3) == 0) read_random();
            off = off + $urandom_range(0, 30000);
            if (off > 65536 && $urandom_range(0, 1) == 1) off = 65536;
        end
    endtask

    task automatic test_directed;
        // Opaque black to white over the whole table, then extremes.
        add_stop(17'd0, 64'hFFFF_0000_0000_0000, 1'b0);
        add_stop(gtb_pkg::OFFSET_ONE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        read_entry(10'd0);
        read_entry(10'd128);
        read_entry(10'd255);
        read_entry(10'd1023);               // beyond the table
        // Single stop that is also the last; offset above one saturates.
        add_stop(17'h1FFFF, 64'h8000_FF00_00FF_5500, 1'b1);
        read_entry(10'd17);
        // Offset going back gives a span of a single entry.
        add_stop(17'd40000, 64'hFF00_12FF_3400_5600, 1'b0);
        add_stop(17'd10000, 64'h00FF_FF00_FF00_FF00, 1'b0);
        add_stop(17'd40001, 64'h7777_8888_9999_AAAA, 1'b0);
        add_stop(17'd40300, 64'hFFFF_0000_FFFF_0000, 1'b1);
        read_entry(10'd156);
        read_entry(10'd200);
    endtask

    task automatic test_entry_sizes;
        logic [10:0] sizes[6];
        sizes = '{11'd2, 11'd0, 11'd3, 11'd2047, 11'd1024, 11'd17};
        foreach (sizes[i]) begin
            write_entries(sizes[i]);
            build_gradient();
            repeat (4) read_random();
        end
        write_entries(gtb_pkg::ENTRIES_RESET);
    endtask

    // Receiver holds off for a long time while stops keep coming.
    task automatic test_backpressure;
        wait_drained();
        hold_off = 1'b1;
        for (int i = 0; i < 6; i++) read_random();
        build_gradient();
        hold_off = 1'b0;
    endtask

    task automatic test_random;
        for (int phase = 0; phase < 12; phase++) begin
            if (phase % 3 == 2) write_entries(11'($urandom_range(2, 64)));
            if (phase % 3 == 0) write_entries(11'($urandom_range(1, 300)));
            rx_random = (phase % 4 != 3);
            for (int k = 0; k < 42; k++) begin
                if ($urandom_range(0, 2) == 0) build_gradient();
                else read_random();
                if ($urandom_range(0, 19) == 0)
                    send_beat(gtb_pkg::CMD_ADD_STOP, 17'($urandom), random_color(), 1'b1,
                              10'($urandom));
            end
        end
        rx_random = 1'b1;
        for (int k = 0; k < 12; k++) build_gradient();
    endtask

    // Receiver: random stall per beat, plus the long hold-off when asked.
    initial begin
        int unsigned gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            gap = rx_random ? $urandom_range(0, 8) : 0;
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end else if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Result checker and stall watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result beat: pixel actual %h", m_tdata[31:0]);
                    error_count++;
                end else begin
                    result_t r;
                    r = pending_results.pop_front();
                    if (m_tdata[31:0] !== r.pixel) begin
                        $error("read_pixel expected %h actual %h", r.pixel, m_tdata[31:0]);
                        error_count++;
                    end
                    if (m_tdata[32] !== r.ready) begin
                        $error("table_ready expected %0d actual %0d", r.ready, m_tdata[32]);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        s_tuser     = gtb_pkg::CMD_ADD_STOP;
        cfg_valid   = 1'b0;
        cfg_data    = gtb_pkg::ENTRIES_RESET;
        error_count = 0;
        idle_cycles = 0;
        hold_off    = 1'b0;
        rx_random   = 1'b1;
        entries_reg = gtb_pkg::ENTRIES_RESET;
        prev_pos = '0; prev_col = '0; first_col = '0;
        wr_ptr = 0; stops_seen = 0; table_done = 1'b0;
        foreach (lut[i]) begin
            lut[i] = '0;
            lut_valid[i] = 1'b0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_entry_sizes();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (300) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            if (pending_results.size() != 0)
                $error("%0d expected results never arrived", pending_results.size());
            $display("status: fail");
        end
        $finish;
    end
endmodule

// File: files.f
sv/gtb_pkg.sv
sv/gtb_divider.sv
sv/gradient_table_builder_unit.sv
verif/gradient_table_builder_unit_tb.sv
